FILE: hdl/tcw_pkg.sv
// shared types, codes and constants of the text console writer
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int TYPE_W  = 4;
    localparam int ATTR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int POS_W   = 11;
    localparam int CELL_W  = CHAR_W + ATTR_W;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] NULL_CHAR    = 8'h00;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [ATTR_W-1:0] WHITE_ATTR   = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {WHITE_ATTR, BLANK_CHAR};

    typedef logic [2:0] t_op;
    localparam t_op OP_NOP     = 3'd0;
    localparam t_op OP_NEWLINE = 3'd1;
    localparam t_op OP_PUT     = 3'd2;
    localparam t_op OP_ERASE   = 3'd3;
    localparam t_op OP_READ    = 3'd4;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] character;
        logic [ATTR_W-1:0] attr;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_cmd;

    function automatic logic [ATTR_W-1:0] attr_of(input logic [TYPE_W-1:0] color_type);
        logic [ATTR_W-1:0] a;
        case (color_type)
            4'd0:    a = 8'h0F;
            4'd1:    a = 8'h04;
            4'd2:    a = 8'h0E;
            4'd3:    a = 8'h01;
            4'd4:    a = 8'h02;
            4'd5:    a = 8'h03;
            4'd6:    a = 8'h05;
            4'd7:    a = 8'h06;
            4'd8:    a = 8'h07;
            4'd9:    a = 8'h08;
            4'd10:   a = 8'h09;
            4'd11:   a = 8'h0A;
            4'd12:   a = 8'h0B;
            4'd13:   a = 8'h0C;
            4'd14:   a = 8'h0D;
            default: a = WHITE_ATTR;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tcw_if.sv
// valid/ready channel interfaces for console items and results
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] character;
    logic [TYPE_W-1:0] color_type;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;

    modport source (output valid, kind, character, color_type, read_row, read_col,
                    input ready);
    modport sink   (input valid, kind, character, color_type, read_row, read_col,
                    output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;

    modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

`default_nettype wire

FILE: hdl/text_console_writer_unit.sv
// text console writer: each item is registered in the back end, then in the result register
// the back end takes no new item until its finish state ends and the result register is free
// a put into a row blanked by reset or scroll first clears that row, in the sweep state
// items queue two deep in front of the back end, so input stays open while it works until full
// reset (synchronous): cursor home, every row marked blank, no result pending, no clear pass
`default_nettype none

module text_console_writer_unit import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tcw_in_if.sink     i_item,
    tcw_out_if.source  o_result
);

    logic q_full;
    logic q_push;
    t_cmd front_cmd;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    tcw_front u_front (
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_res       (o_result)
    );

endmodule

`default_nettype wire

FILE: hdl/tcw_front.sv
// front end: accepts items and classifies them into console commands
`default_nettype none

module tcw_front import tcw_pkg::*; (
    tcw_in_if.sink i_item,
    input  wire    i_q_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    assign i_item.ready = !i_q_full;
    assign o_push       = i_item.valid && !i_q_full;

    always_comb begin
        o_cmd.op        = OP_NOP;
        o_cmd.character = i_item.character;
        o_cmd.attr      = attr_of(i_item.color_type);
        o_cmd.read_row  = i_item.read_row;
        o_cmd.read_col  = i_item.read_col;
        case (i_item.kind)
            KIND_PUT: begin
                if (i_item.character == NEWLINE_CHAR) begin
                    o_cmd.op = OP_NEWLINE;
                end else if (i_item.character != NULL_CHAR) begin
                    o_cmd.op = OP_PUT;
                end
            end
            KIND_ERASE: o_cmd.op = OP_ERASE;
            KIND_READ:  o_cmd.op = OP_READ;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/tcw_queue.sv
// short command queue between the front end and the execution unit
`default_nettype none

module tcw_queue import tcw_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  wire  i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tcw_back.sv
// execution unit: cursor, row ring, screen memory and result register
`default_nettype none

module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    tcw_out_if.source  o_res
);

    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CCW       = $clog2(COLUMNS + 1);
    localparam int AW        = RW + CW;
    localparam int MEM_DEPTH = ROWS * (2 ** CW);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIN   = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [RW-1:0]     r_cur_row, n_cur_row;
    logic [CCW-1:0]    r_cur_col, n_cur_col;
    logic [CCW-1:0]    r_prev_col, n_prev_col;
    logic [RW-1:0]     r_top, n_top;
    logic [ROWS-1:0]   r_blank, n_blank;
    logic [CW-1:0]     r_sweep_col, n_sweep_col;

    t_op               r_op, n_op;
    logic [RW-1:0]     r_wr_row, n_wr_row;
    logic [CW-1:0]     r_wr_col, n_wr_col;
    logic [CELL_W-1:0] r_wr_cell, n_wr_cell;
    logic              r_rd_ok, n_rd_ok;
    logic              r_rd_blank, n_rd_blank;

    logic              r_out_valid, n_out_valid;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic [ATTR_W-1:0] r_out_attr, n_out_attr;

    logic [CELL_W-1:0] r_mem [MEM_DEPTH];
    logic [CELL_W-1:0] r_rd_data;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic              wrap;
    logic [RW-1:0]     rd_row;
    logic [POS_W-1:0]  pos;

    // logical row to physical row through the scroll ring
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] l, input logic [RW-1:0] t);
        logic [RW:0] s;
        s = {1'b0, l} + {1'b0, t};
        if (s >= (RW + 1)'(ROWS)) begin
            s = s - (RW + 1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    assign pos = POS_W'(r_cur_row) * POS_W'(COLUMNS) + POS_W'(r_cur_col);

    assign o_res.valid      = r_out_valid;
    assign o_res.cursor_pos = r_out_pos;
    assign o_res.cell_char  = r_out_char;
    assign o_res.cell_attr  = r_out_attr;

    always_comb begin
        n_state     = r_state;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_prev_col  = r_prev_col;
        n_top       = r_top;
        n_blank     = r_blank;
        n_sweep_col = r_sweep_col;
        n_op        = r_op;
        n_wr_row    = r_wr_row;
        n_wr_col    = r_wr_col;
        n_wr_cell   = r_wr_cell;
        n_rd_ok     = r_rd_ok;
        n_rd_blank  = r_rd_blank;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_pos   = r_out_pos;
        n_out_char  = r_out_char;
        n_out_attr  = r_out_attr;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = BLANK_CELL;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        wrap        = 1'b0;
        rd_row      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (!r_out_valid || o_res.ready)) begin
                    o_pop     = 1'b1;
                    n_op      = i_cmd.op;
                    n_state   = S_FIN;
                    n_wr_cell = {i_cmd.attr, i_cmd.character};
                    wrap = (i_cmd.op == OP_NEWLINE) ||
                           ((i_cmd.op == OP_PUT) && (r_cur_col >= CCW'(COLUMNS)));
                    if (wrap) begin
                        n_prev_col = r_cur_col;
                        n_cur_col  = '0;
                        if (r_cur_row == RW'(ROWS - 1)) begin
                            // scroll: the old top row becomes the blank bottom row
                            n_top = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
                            n_blank[r_top] = 1'b1;
                        end else begin
                            n_cur_row = r_cur_row + 1'b1;
                        end
                    end
                    case (i_cmd.op)
                        OP_PUT: begin
                            n_wr_row  = phys_row(n_cur_row, n_top);
                            n_wr_col  = n_cur_col[CW-1:0];
                            n_cur_col = n_cur_col + 1'b1;
                        end
                        OP_ERASE: begin
                            if (r_cur_col != '0) begin
                                n_cur_col = r_cur_col - 1'b1;
                            end else if (r_cur_row != '0) begin
                                n_cur_col = (r_prev_col >= CCW'(COLUMNS)) ?
                                            r_prev_col - 1'b1 : r_prev_col;
                                n_cur_row = r_cur_row - 1'b1;
                            end
                            n_wr_row = phys_row(n_cur_row, r_top);
                            n_wr_col = n_cur_col[CW-1:0];
                        end
                        OP_READ: begin
                            n_rd_ok = (i_cmd.read_row < ROW_W'(ROWS)) &&
                                      (i_cmd.read_col < COL_W'(COLUMNS));
                            rd_row     = phys_row(i_cmd.read_row[RW-1:0], r_top);
                            mem_re     = 1'b1;
                            mem_raddr  = {rd_row, i_cmd.read_col[CW-1:0]};
                            n_rd_blank = n_rd_ok ? r_blank[rd_row] : 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_FIN: begin
                n_out_char = '0;
                n_out_attr = '0;
                n_out_pos  = pos;
                if ((r_op == OP_PUT) && r_blank[r_wr_row]) begin
                    // stale row: clear it before the first write
                    n_state     = S_SWEEP;
                    n_sweep_col = '0;
                end else begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    case (r_op)
                        OP_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = {r_wr_row, r_wr_col};
                            mem_wdata = r_wr_cell;
                        end
                        OP_ERASE: begin
                            mem_we    = !r_blank[r_wr_row];
                            mem_waddr = {r_wr_row, r_wr_col};
                            mem_wdata = BLANK_CELL;
                        end
                        OP_READ: begin
                            if (r_rd_ok) begin
                                n_out_char = r_rd_blank ? BLANK_CHAR : r_rd_data[CHAR_W-1:0];
                                n_out_attr = r_rd_blank ? WHITE_ATTR : r_rd_data[CELL_W-1:CHAR_W];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                mem_we      = 1'b1;
                mem_waddr   = {r_wr_row, r_sweep_col};
                mem_wdata   = BLANK_CELL;
                n_sweep_col = r_sweep_col + 1'b1;
                if (r_sweep_col == CW'(COLUMNS - 1)) begin
                    n_blank[r_wr_row] = 1'b0;
                    n_state           = S_FIN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_prev_col  <= '0;
            r_top       <= '0;
            r_blank     <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_prev_col  <= n_prev_col;
            r_top       <= n_top;
            r_blank     <= n_blank;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sweep_col <= n_sweep_col;
        r_op        <= n_op;
        r_wr_row    <= n_wr_row;
        r_wr_col    <= n_wr_col;
        r_wr_cell   <= n_wr_cell;
        r_rd_ok     <= n_rd_ok;
        r_rd_blank  <= n_rd_blank;
        r_out_pos   <= n_out_pos;
        r_out_char  <= n_out_char;
        r_out_attr  <= n_out_attr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_row < RW'(ROWS)) && (r_cur_col <= CCW'(COLUMNS)) &&
        (r_prev_col <= CCW'(COLUMNS)))
        else $error("cursor out of screen bounds");

    a_top_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top < RW'(ROWS))
        else $error("scroll ring top out of range");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !r_out_valid)
        else $error("result register would be overwritten");

    a_sweep_clears_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_sweep_col == CW'(COLUMNS - 1))
        |=> (r_state == S_FIN && !r_blank[r_wr_row]))
        else $error("row clear did not finish");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && i_cmd_valid))
        else $error("command taken outside idle");

endmodule

`default_nettype wire

FILE: test/tb_text_console_writer_unit.sv
// self-checking testbench of the text console writer: shadow screen, valid/ready stimulus, stalls
module tb_text_console_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int COLS           = DEF_COLUMNS;
    localparam int NROWS          = DEF_ROWS;
    localparam int NCELLS         = COLS * NROWS;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 4 * COLS;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // attribute per color type, type 0 in the low byte
    localparam logic [16*ATTR_W-1:0] COLOR_ATTRS = {
        8'h0F, 8'h0D, 8'h0C, 8'h0B, 8'h0A, 8'h09, 8'h08, 8'h07,
        8'h06, 8'h05, 8'h03, 8'h02, 8'h01, 8'h0E, 8'h04, 8'h0F
    };

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
    } t_console_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcw_in_if  item_if ();
    tcw_out_if result_if ();

    text_console_writer_unit #(
        .COLUMNS (COLS),
        .ROWS    (NROWS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow copy of the console
    logic [CELL_W-1:0] shadow_screen [NCELLS];
    logic [ROW_W-1:0]  shadow_row;
    logic [COL_W-1:0]  shadow_col;
    logic [COL_W-1:0]  shadow_prev_col;

    t_console_reply awaited_replies [$];

    int  errors          = 0;
    int  items_accepted  = 0;
    int  replies_checked = 0;
    int  scrolls_seen    = 0;
    int  wraps_seen      = 0;
    int  back_rows_seen  = 0;
    int  quiet_cycles    = 0;
    bit  idling_on       = 1'b1;
    bit  rx_hold_req     = 1'b0;
    int  rx_stall_left   = 0;

    function automatic void clear_shadow_console();
        for (int i = 0; i < NCELLS; i++) shadow_screen[i] = BLANK_CELL;
        shadow_row      = '0;
        shadow_col      = '0;
        shadow_prev_col = '0;
    endfunction

    function automatic void store_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                       input logic [CELL_W-1:0] v);
        if (r < NROWS && c < COLS) shadow_screen[int'(r) * COLS + int'(c)] = v;
    endfunction

    function automatic void break_line();
        shadow_prev_col = shadow_col;
        shadow_col      = '0;
        if (shadow_row == NROWS - 1) begin
            for (int i = 0; i < (NROWS - 1) * COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
            for (int i = (NROWS - 1) * COLS; i < NCELLS; i++) shadow_screen[i] = BLANK_CELL;
            scrolls_seen++;
        end else begin
            shadow_row++;
        end
    endfunction

    function automatic t_console_reply apply_console_item(input logic [KIND_W-1:0] kind,
                                                          input logic [CHAR_W-1:0] ch,
                                                          input logic [TYPE_W-1:0] ty,
                                                          input logic [ROW_W-1:0]  rr,
                                                          input logic [COL_W-1:0]  rc);
        t_console_reply r;
        r = '0;
        case (kind)
            KIND_PUT: begin
                if (ch == NEWLINE_CHAR) begin
                    break_line();
                end else if (ch != NULL_CHAR) begin
                    if (shadow_col >= COLS) begin
                        break_line();
                        wraps_seen++;
                    end
                    store_cell(shadow_row, shadow_col, {COLOR_ATTRS[int'(ty) * ATTR_W +: ATTR_W], ch});
                    shadow_col++;
                end
            end
            KIND_ERASE: begin
                if (shadow_col != 0) begin
                    shadow_col--;
                end else if (shadow_row != 0) begin
                    // a full previous row leaves its column one past the end
                    shadow_col = (shadow_prev_col >= COLS) ? shadow_prev_col - 1'b1 : shadow_prev_col;
                    shadow_row--;
                    back_rows_seen++;
                end
                store_cell(shadow_row, shadow_col, BLANK_CELL);
            end
            KIND_READ: begin
                if (rr < NROWS && rc < COLS) {r.attr, r.ch} = shadow_screen[int'(rr) * COLS + int'(rc)];
            end
            default: ;
        endcase
        r.pos = POS_W'(int'(shadow_row) * COLS + int'(shadow_col));
        return r;
    endfunction

    // predict on each accepted item, then compare each accepted result
    always @(posedge i_clk) begin : track_console
        t_console_reply want;
        t_console_reply got;
        if (i_rst_n) begin
            if (item_if.valid && item_if.ready) begin
                awaited_replies.push_back(apply_console_item(item_if.kind, item_if.character,
                                                             item_if.color_type, item_if.read_row,
                                                             item_if.read_col));
                items_accepted++;
            end
            if (result_if.valid && result_if.ready) begin
                got.pos  = result_if.cursor_pos;
                got.ch   = result_if.cell_char;
                got.attr = result_if.cell_attr;
                if (awaited_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result pos %0d char 0x%02h attr 0x%02h",
                             $time, got.pos, got.ch, got.attr);
                end else begin
                    want = awaited_replies.pop_front();
                    replies_checked++;
                    if (got.pos !== want.pos) begin
                        errors++;
                        $display("%0t: cursor_pos expected %0d actual %0d", $time, want.pos, got.pos);
                    end
                    if (got.ch !== want.ch) begin
                        errors++;
                        $display("%0t: cell_char expected 0x%02h actual 0x%02h",
                                 $time, want.ch, got.ch);
                    end
                    if (got.attr !== want.attr) begin
                        errors++;
                        $display("%0t: cell_attr expected 0x%02h actual 0x%02h",
                                 $time, want.attr, got.attr);
                    end
                end
            end
        end
    end

    // result side: random stall bursts and the long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req   = 1'b0;
            rx_stall_left = HOLD_CYCLES;
        end
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            result_if.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 15) == 0) begin
            rx_stall_left = $urandom_range(0, 13);
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, awaited_replies.size());
            $display("tb_text_console_writer_unit: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                             input logic [TYPE_W-1:0] ty, input logic [ROW_W-1:0] rr,
                             input logic [COL_W-1:0] rc);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.kind       <= kind;
        item_if.character  <= ch;
        item_if.color_type <= ty;
        item_if.read_row   <= rr;
        item_if.read_col   <= rc;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [TYPE_W-1:0] ty);
        send_item(KIND_PUT, ch, ty, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic erase_cell();
        send_item(KIND_ERASE, CHAR_W'($urandom), TYPE_W'($urandom), ROW_W'($urandom),
                  COL_W'($urandom));
    endtask

    task automatic read_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        send_item(KIND_READ, CHAR_W'($urandom), TYPE_W'($urandom), r, c);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] rand_glyph();
        logic [CHAR_W-1:0] g;
        do g = CHAR_W'($urandom); while (g == NULL_CHAR || g == NEWLINE_CHAR);
        return g;
    endfunction

    task automatic test_directed();
        read_cell(0, 0);
        read_cell('1, '1);
        read_cell(ROW_W'(NROWS - 1), COL_W'(COLS - 1));
        read_cell(ROW_W'(NROWS), 0);
        read_cell(0, COL_W'(COLS));
        erase_cell();                 // at home: cursor stays, cell blanked
        put_char(NULL_CHAR, 4'd3);    // ignored
        put_char(8'hFF, 4'd15);
        put_char(8'h01, 4'd14);
        put_char(8'h41, 4'd0);
        put_char(8'h7E, 4'd1);
        put_char(8'h80, 4'd2);
        send_item(KIND_SPARE, 8'h55, 4'd7, 5'd3, 7'd3);
        read_cell(0, 0);
        read_cell(0, 4);
        put_char(NEWLINE_CHAR, 4'd5);
        erase_cell();                 // back across the row to the saved column
        read_cell(0, 4);
        put_char(NEWLINE_CHAR, 4'd0);
        put_char(NEWLINE_CHAR, 4'd9);
        erase_cell();
        read_cell(0, 5);
    endtask

    task automatic test_line_wrap();
        put_char(NEWLINE_CHAR, TYPE_W'($urandom));
        repeat (COLS) put_char(rand_glyph(), TYPE_W'($urandom));
        erase_cell();                 // column one past the end steps back to the last
        put_char(rand_glyph(), TYPE_W'($urandom));
        put_char(NEWLINE_CHAR, TYPE_W'($urandom));
        erase_cell();                 // saved column is the full width
        read_cell(shadow_row, COL_W'(COLS - 1));
        repeat (2) put_char(rand_glyph(), TYPE_W'($urandom));
        repeat (COLS + 5) put_char(rand_glyph(), TYPE_W'($urandom));
        repeat (10) read_cell(shadow_row, COL_W'($urandom_range(0, COLS - 1)));
        repeat (COLS - 5) put_char(rand_glyph(), TYPE_W'($urandom));
        put_char(NEWLINE_CHAR, TYPE_W'($urandom));
        repeat (3) put_char(rand_glyph(), TYPE_W'($urandom));
        repeat (8) erase_cell();
        repeat (6) read_cell(ROW_W'($urandom_range(0, 4)), COL_W'($urandom_range(0, COLS - 1)));
    endtask

    task automatic test_scroll();
        repeat (NROWS + 5) begin
            repeat ($urandom_range(1, 6)) put_char(rand_glyph(), TYPE_W'($urandom));
            put_char(NEWLINE_CHAR, TYPE_W'($urandom));
        end
        for (int r = 0; r < NROWS; r += 8) read_cell(ROW_W'(r), COL_W'($urandom_range(0, 6)));
        read_cell(ROW_W'(NROWS - 2), 0);
        read_cell(ROW_W'(NROWS - 1), 0);
        erase_cell();                 // bottom row, column zero: back to the row above
        repeat (3) put_char(rand_glyph(), TYPE_W'($urandom));
        repeat (5) put_char(NEWLINE_CHAR, TYPE_W'($urandom));
        repeat (4) read_cell(ROW_W'(NROWS - 1), COL_W'($urandom_range(0, COLS - 1)));
    endtask

    task automatic test_backpressure();
        pause_until_drained();
        rx_hold_req = 1'b1;
        repeat (16) begin
            if ($urandom_range(0, 1) == 0) put_char(rand_glyph(), TYPE_W'($urandom));
            else read_cell(ROW_W'($urandom_range(0, NROWS - 1)), COL_W'($urandom_range(0, COLS - 1)));
        end
        pause_until_drained();
    endtask

    task automatic test_random_mix(input int n_items);
        int target;
        int mode;
        int pick;
        target = items_accepted + n_items;
        while (items_accepted < target) begin
            mode = $urandom_range(0, 9);
            if (mode <= 4) begin
                // typed line, now and then long enough to wrap
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(70, 170)) put_char(rand_glyph(), TYPE_W'($urandom));
                else
                    repeat ($urandom_range(0, 30)) put_char(rand_glyph(), TYPE_W'($urandom));
                if ($urandom_range(0, 4) != 0) put_char(NEWLINE_CHAR, TYPE_W'($urandom));
            end else if (mode == 5) begin
                repeat ($urandom_range(1, 12)) erase_cell();
            end else if (mode <= 7) begin
                repeat ($urandom_range(1, 8)) begin
                    pick = $urandom_range(0, 6);
                    if (pick == 0)
                        read_cell(ROW_W'($urandom), COL_W'($urandom));
                    else if (pick <= 3)
                        read_cell(shadow_row, COL_W'($urandom_range(0, COLS - 1)));
                    else
                        read_cell(ROW_W'($urandom_range(0, NROWS - 1)),
                                  COL_W'($urandom_range(0, COLS - 1)));
                end
            end else if (mode == 8) begin
                repeat ($urandom_range(1, 6))
                    send_item(KIND_W'($urandom), CHAR_W'($urandom), TYPE_W'($urandom),
                              ROW_W'($urandom), COL_W'($urandom));
            end else begin
                repeat ($urandom_range(1, 30)) put_char(NEWLINE_CHAR, TYPE_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        item_if.valid      = 1'b0;
        item_if.kind       = KIND_PUT;
        item_if.character  = NULL_CHAR;
        item_if.color_type = '0;
        item_if.read_row   = '0;
        item_if.read_col   = '0;
        result_if.ready    = 1'b0;
        clear_shadow_console();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_line_wrap();
        test_scroll();
        test_backpressure();
        test_random_mix(1000);
        pause_until_drained();
        idling_on = 1'b0;
        test_random_mix(200);
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (awaited_replies.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, awaited_replies.size());
        end
        $display("covered %0d items: %0d line wraps, %0d scrolls, %0d erases back across rows",
                 items_accepted, wraps_seen, scrolls_seen, back_rows_seen);
        $display("checked %0d results, %0d mismatches", replies_checked, errors);
        if (errors == 0) begin
            $display("tb_text_console_writer_unit: done, clean");
        end else begin
            $display("tb_text_console_writer_unit: done, errors");
        end
        $finish;
    end

endmodule
